[sv/tbra_pkg.sv]
// Package with shared types and constants of the transmit bounce ring allocator.
package tbra_pkg;

  localparam logic [1:0] KIND_PLACED = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_RETIRE = 2'd2;

  localparam logic [1:0] CFG_RING_BYTES = 2'd0;
  localparam logic [1:0] CFG_DESC_LIMIT = 2'd1;
  localparam logic [1:0] CFG_PAD_LOG2   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_in;      // latch input item, store segment
    logic chk_clear;    // start check walk from live head
    logic chk_step;     // accumulate one segment of the check walk
    logic dec_eval;     // register accept/reject decision
    logic place_step;   // place one segment and emit it
    logic rej_emit;     // emit reject result
    logic ret_step;     // retire one slot
    logic ret_emit;     // emit retire report
  } tbra_cmd_t;

  typedef struct packed {
    logic is_cmpl;      // latched item is a completion update
    logic seg_last;     // latched segment is last
    logic walk_done;    // segment index reached pending count
    logic ok;           // registered accept decision
    logic ret_more;     // another slot may be retired
  } tbra_sts_t;

endpackage

[sv/tbra_if.sv]
// Valid/ready channel interface with a generic payload.
interface tbra_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/tbra_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module tbra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[sv/tbra_ctrl.sv]
// Controller state machine of the transmit bounce ring allocator.
module tbra_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tbra_pkg::tbra_sts_t sts,
  output tbra_pkg::tbra_cmd_t cmd
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DISP  = 8'b0000_0010,
    S_CHK   = 8'b0000_0100,
    S_DEC   = 8'b0000_1000,
    S_PLACE = 8'b0001_0000,
    S_EMIT  = 8'b0010_0000,
    S_RET   = 8'b0100_0000,
    S_RREP  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   place_mode_r, place_mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      place_mode_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      place_mode_r <= place_mode_nxt;
    end
  end

  // S_EMIT holds a result on the output until its transfer.
  always_comb begin
    state_nxt      = state_r;
    place_mode_nxt = place_mode_r;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.is_cmpl) begin
          state_nxt = S_RET;
        end else if (sts.seg_last) begin
          cmd.chk_clear = 1'b1;
          state_nxt     = S_CHK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CHK: begin
        if (sts.walk_done) begin
          state_nxt = S_DEC;
        end else begin
          cmd.chk_step = 1'b1;
        end
      end
      S_DEC: begin
        cmd.dec_eval = 1'b1;
        state_nxt    = S_PLACE;
      end
      S_PLACE: begin
        if (sts.ok) begin
          cmd.place_step = 1'b1;
          place_mode_nxt = 1'b1;
        end else begin
          cmd.rej_emit   = 1'b1;
          place_mode_nxt = 1'b0;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (place_mode_r && !sts.walk_done) begin
            state_nxt = S_PLACE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RET: begin
        if (sts.ret_more) begin
          cmd.ret_step = 1'b1;
        end else begin
          cmd.ret_emit   = 1'b1;
          place_mode_nxt = 1'b0;
          state_nxt      = S_RREP;
        end
      end
      S_RREP: begin
        state_nxt = S_EMIT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule

[sv/tbra_dp.sv]
// Datapath of the transmit bounce ring allocator: state, memories and placement.
module tbra_dp #(
  parameter int RING_DEPTH   = 1024,
  parameter int MAX_SEGS     = 16,
  parameter int CLEAN_BUDGET = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [20:0]         cfg_wdata,
  input  logic                in_op,
  input  logic [15:0]         in_seg_len,
  input  logic                in_seg_last,
  input  logic [31:0]         in_done_count,
  input  tbra_pkg::tbra_cmd_t cmd,
  output tbra_pkg::tbra_sts_t sts,
  output logic [1:0]          out_kind,
  output logic [9:0]          out_slot,
  output logic [19:0]         out_offset,
  output logic [21:0]         out_alloc_bytes,
  output logic [6:0]          out_seg_total,
  output logic [10:0]         out_retired,
  output logic [20:0]         out_used_bytes,
  output logic                out_is_last
);
  localparam int SW = $clog2(RING_DEPTH);
  localparam int PW = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
  localparam int PD = (MAX_SEGS > 1) ? MAX_SEGS : 2;
  localparam int CW = $clog2(MAX_SEGS + 1);
  localparam int BW = $clog2(CLEAN_BUDGET + 1);
  localparam logic [31:0] RING_DEPTH_W = 32'(RING_DEPTH);

  logic [20:0] ring_bytes_r;
  logic [10:0] desc_limit_r;
  logic [3:0]  pad_log2_r;
  logic [20:0] place_head_r, place_head_nxt;
  logic [20:0] bytes_used_r;
  logic [31:0] desc_head_r, desc_tail_r;
  logic [CW-1:0] pend_cnt_r;
  logic [6:0]  seg_seen_r;
  logic        op_r, last_r;
  logic [31:0] target_r;
  logic [CW-1:0] idx_r;
  logic [20:0] chk_head_r, chk_head_nxt;
  logic [22:0] need_r;
  logic        ok_r;
  logic [BW-1:0] ret_n_r;
  logic [6:0]  total_r;

  // Pending segment lengths. The read address runs one step ahead of the index
  // so that the registered read data matches the index in the next cycle.
  logic          pl_we;
  logic [PW-1:0] pl_waddr, pl_raddr;
  logic [15:0]   pl_rdata;
  assign pl_we    = cmd.take_in && !in_op && (pend_cnt_r < CW'(MAX_SEGS));
  assign pl_waddr = PW'(pend_cnt_r);
  assign pl_raddr = (cmd.chk_clear || cmd.dec_eval) ? '0 :
                    (cmd.chk_step || cmd.place_step) ? PW'(idx_r + CW'(1)) :
                    PW'(idx_r);

  tbra_ram #(.WIDTH(16), .DEPTH(PD)) u_pend (
    .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(in_seg_len),
    .raddr(pl_raddr), .rdata(pl_rdata)
  );

  // Charge per descriptor slot.
  logic          sc_we;
  logic [21:0]   sc_wdata, sc_rdata;
  logic [SW-1:0] sc_raddr;
  assign sc_raddr = cmd.ret_step ? SW'(desc_tail_r + 32'd1) : SW'(desc_tail_r);

  tbra_ram #(.WIDTH(22), .DEPTH(RING_DEPTH)) u_charge (
    .clk(clk), .we(sc_we), .waddr(SW'(desc_head_r)), .wdata(sc_wdata),
    .raddr(sc_raddr), .rdata(sc_rdata)
  );

  // One placement step: pad, wrap test, charge.
  function automatic logic [43:0] place(input logic [15:0] len, input logic [20:0] hd,
                                        input logic [3:0] pl, input logic [20:0] rb);
    logic [29:0] a, p;
    logic [21:0] h, remain, nh, chg;
    a = 30'd1 << pl;
    p = (30'(len) + a - 30'd1) & ~(a - 30'd1);
    h = (hd >= rb) ? 22'd0 : 22'(hd);
    remain = 22'(rb) - h;
    chg = 22'(p);
    if (p > 30'(remain)) begin
      chg = 22'(p + 30'(remain));
      h   = 22'd0;
    end
    nh  = 22'(30'(h) + p);
    if (nh == 22'(rb)) begin
      nh = 22'd0;
    end
    return {1'b0, nh[20:0], chg};
  endfunction

  logic [43:0] chk_res, plc_res;
  assign chk_res = place(pl_rdata, chk_head_r, pad_log2_r, ring_bytes_r);
  assign plc_res = place(pl_rdata, place_head_r, pad_log2_r, ring_bytes_r);
  logic wrapped;
  logic [20:0] adj_head;
  assign adj_head = (place_head_r >= ring_bytes_r) ? 21'd0 : place_head_r;
  assign wrapped  = 22'(plc_res[21:0]) > 22'(ring_bytes_r - adj_head) ||
                    (plc_res[21:0] != 22'd0 && 23'(plc_res[21:0]) >
                     23'(ring_bytes_r) - 23'(adj_head));
  assign sc_wdata = plc_res[21:0];
  assign sc_we    = cmd.place_step;
  assign place_head_nxt = plc_res[42:22];
  assign chk_head_nxt   = chk_res[42:22];

  logic [10:0] lim;
  logic [31:0] outstanding;
  assign lim = (desc_limit_r < 11'(RING_DEPTH_W > 32'd2047 ? 32'd2047 : RING_DEPTH_W))
               ? desc_limit_r : 11'(RING_DEPTH_W > 32'd2047 ? 32'd2047 : RING_DEPTH_W);
  assign outstanding = desc_head_r - desc_tail_r;

  logic [20:0] freed;
  assign freed = (22'(sc_rdata) > 22'(bytes_used_r)) ? 21'd0 :
                 bytes_used_r - 21'(sc_rdata);

  // The pending count returns to zero once the last segment of a packet is placed or the packet is rejected.
  assign sts.is_cmpl   = op_r;
  assign sts.seg_last  = last_r;
  assign sts.walk_done = (idx_r == pend_cnt_r) || (pend_cnt_r == '0);
  assign sts.ok        = ok_r;
  assign sts.ret_more  = (desc_tail_r != target_r) && (desc_tail_r != desc_head_r) &&
                         (ret_n_r < BW'(CLEAN_BUDGET));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_bytes_r <= 21'd65536;
      desc_limit_r <= 11'd1024;
      pad_log2_r   <= 4'd6;
      place_head_r <= '0;
      bytes_used_r <= '0;
      desc_head_r  <= '0;
      desc_tail_r  <= '0;
      pend_cnt_r   <= '0;
      seg_seen_r   <= '0;
      idx_r        <= '0;
      ok_r         <= 1'b0;
      ret_n_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tbra_pkg::CFG_RING_BYTES: ring_bytes_r <= cfg_wdata;
          tbra_pkg::CFG_DESC_LIMIT: desc_limit_r <= cfg_wdata[10:0];
          tbra_pkg::CFG_PAD_LOG2:   pad_log2_r   <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (cmd.take_in) begin
        op_r     <= in_op;
        last_r   <= in_seg_last;
        target_r <= in_done_count;
        ret_n_r  <= '0;
        if (!in_op) begin
          if (pend_cnt_r < CW'(MAX_SEGS)) begin
            pend_cnt_r <= pend_cnt_r + CW'(1);
          end
          if (seg_seen_r != 7'd127) begin
            seg_seen_r <= seg_seen_r + 7'd1;
          end
        end
      end
      if (cmd.chk_clear) begin
        idx_r      <= '0;
        chk_head_r <= place_head_r;
        need_r     <= '0;
        total_r    <= seg_seen_r;
      end
      if (cmd.chk_step) begin
        idx_r      <= idx_r + CW'(1);
        chk_head_r <= chk_head_nxt;
        need_r     <= need_r + 23'(chk_res[21:0]);
      end
      if (cmd.dec_eval) begin
        idx_r <= '0;
        ok_r  <= (total_r <= 7'(MAX_SEGS)) &&
                 (33'(outstanding) + 33'(pend_cnt_r) <= 33'(lim)) &&
                 (24'(bytes_used_r) + 24'(need_r) <= 24'(ring_bytes_r));
        if ((total_r <= 7'(MAX_SEGS)) &&
            (33'(outstanding) + 33'(pend_cnt_r) <= 33'(lim)) &&
            (24'(bytes_used_r) + 24'(need_r) <= 24'(ring_bytes_r))) begin
          bytes_used_r <= 21'(24'(bytes_used_r) + 24'(need_r));
        end
        seg_seen_r <= '0;
      end
      if (cmd.place_step) begin
        idx_r        <= idx_r + CW'(1);
        place_head_r <= place_head_nxt;
        desc_head_r  <= desc_head_r + 32'd1;
      end
      if (cmd.ret_step) begin
        bytes_used_r <= freed;
        desc_tail_r  <= desc_tail_r + 32'd1;
        ret_n_r      <= ret_n_r + BW'(1);
      end
      if (cmd.rej_emit || (cmd.place_step && (idx_r + CW'(1) == pend_cnt_r))) begin
        pend_cnt_r <= '0;
      end
    end
  end

  // Result register; the placed offset is the head after a possible wrap.
  always_ff @(posedge clk) begin
    if (cmd.place_step) begin
      out_kind        <= tbra_pkg::KIND_PLACED;
      out_slot        <= 10'(desc_head_r % RING_DEPTH_W);
      out_offset      <= wrapped ? 20'd0 : adj_head[19:0];
      out_alloc_bytes <= plc_res[21:0];
      out_seg_total   <= total_r;
      out_retired     <= '0;
      out_used_bytes  <= bytes_used_r;
      out_is_last     <= (idx_r + CW'(1) == pend_cnt_r);
    end else if (cmd.rej_emit) begin
      out_kind        <= tbra_pkg::KIND_REJECT;
      out_slot        <= '0;
      out_offset      <= '0;
      out_alloc_bytes <= '0;
      out_seg_total   <= total_r;
      out_retired     <= '0;
      out_used_bytes  <= bytes_used_r;
      out_is_last     <= 1'b1;
    end else if (cmd.ret_emit) begin
      out_kind        <= tbra_pkg::KIND_RETIRE;
      out_slot        <= '0;
      out_offset      <= '0;
      out_alloc_bytes <= '0;
      out_seg_total   <= '0;
      out_retired     <= 11'(ret_n_r);
      out_used_bytes  <= bytes_used_r;
      out_is_last     <= 1'b1;
    end
  end
endmodule

[sv/tx_bounce_ring_allocator_top.sv]
// Top level of the transmit bounce ring allocator.
//  channel | dir | carries
//  in      | in  | op, seg_len, seg_last, done_count
//  out     | out | kind, slot, offset, alloc_bytes, seg_total, retired, used_bytes, is_last
//  cfg     | in  | write enable, index, 21-bit data
// A non-last segment passes S_IDLE and S_DISP only; a last segment runs the check walk in
// S_CHK, one pending-length read per step, then S_DEC, then S_PLACE and S_EMIT per placed
// result or one reject. A completion retires one slot per S_RET step, then S_RREP, S_EMIT.
// Reset is synchronous; no clearing pass is needed. A stalled result holds the block.
module tx_bounce_ring_allocator_top #(
  parameter int RING_DEPTH   = 1024,
  parameter int MAX_SEGS     = 16,
  parameter int CLEAN_BUDGET = 256
) (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic [20:0] cfg_wdata,
  input logic        in_valid,
  output logic       in_ready,
  input logic        in_op,
  input logic [15:0] in_seg_len,
  input logic        in_seg_last,
  input logic [31:0] in_done_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [9:0]  out_slot,
  output logic [19:0] out_offset,
  output logic [21:0] out_alloc_bytes,
  output logic [6:0]  out_seg_total,
  output logic [10:0] out_retired,
  output logic [20:0] out_used_bytes,
  output logic        out_is_last
);
  tbra_pkg::tbra_cmd_t cmd;
  tbra_pkg::tbra_sts_t sts;

  tbra_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  tbra_dp #(.RING_DEPTH(RING_DEPTH), .MAX_SEGS(MAX_SEGS), .CLEAN_BUDGET(CLEAN_BUDGET)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_op(in_op), .in_seg_len(in_seg_len),
    .in_seg_last(in_seg_last), .in_done_count(in_done_count), .cmd(cmd), .sts(sts),
    .out_kind(out_kind), .out_slot(out_slot), .out_offset(out_offset),
    .out_alloc_bytes(out_alloc_bytes), .out_seg_total(out_seg_total),
    .out_retired(out_retired), .out_used_bytes(out_used_bytes),
    .out_is_last(out_is_last)
  );

`ifndef NO_ASSERTIONS
  // No new item is taken while a result is offered.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  // A retire report never counts more than the budget.
  a_budget: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == tbra_pkg::KIND_RETIRE) |-> (out_retired <= 11'(CLEAN_BUDGET)))
    else $error("retire count beyond budget");
  // Reject and retire results always end their item.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != tbra_pkg::KIND_PLACED) |-> out_is_last)
    else $error("single result not marked last");
`endif
endmodule

[tb/testbench.sv]
// Self-checking testbench for the transmit bounce ring allocator top level.
module testbench;

  localparam int RING_DEPTH = 1024;
  localparam int MAX_SEGS = 16;
  localparam int CLEAN_BUDGET = 256;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD = 300;

  localparam bit OP_SEGMENT = 1'b0;
  localparam bit OP_COMPLETION = 1'b1;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic        op;
    logic [15:0] seg_len;
    logic        seg_last;
    logic [31:0] done_count;
  } seg_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  slot;
    logic [19:0] offset;
    logic [21:0] alloc_bytes;
    logic [6:0]  seg_total;
    logic [10:0] retired;
    logic [20:0] used_bytes;
    logic        is_last;
  } alloc_res_t;

  class alloc_scoreboard;
    bit [20:0]  ring_bytes;
    bit [10:0]  desc_limit;
    bit [3:0]   pad_log2;
    u64_t       place_head;
    u64_t       bytes_used;
    bit [31:0]  desc_head;
    bit [31:0]  desc_tail;
    u64_t       slot_charge[RING_DEPTH];
    bit [15:0]  pend_len[MAX_SEGS];
    int         pend_cnt;
    int         seg_seen;
    alloc_res_t placements_q[$];
    int         errors;

    function new();
      ring_bytes = 21'd65536;
      desc_limit = 11'd1024;
      pad_log2 = 4'd6;
      place_head = 0;
      bytes_used = 0;
      desc_head = 0;
      desc_tail = 0;
      pend_cnt = 0;
      seg_seen = 0;
      errors = 0;
    endfunction

    function void set_cfg(logic [1:0] idx, logic [20:0] val);
      if (idx == tbra_pkg::CFG_RING_BYTES) ring_bytes = val;
      else if (idx == tbra_pkg::CFG_DESC_LIMIT) desc_limit = val[10:0];
      else if (idx == tbra_pkg::CFG_PAD_LOG2) pad_log2 = val[3:0];
    endfunction

    // Places one segment at head and returns the charge, wasted tail included.
    function u64_t place_seg(bit [15:0] len, inout u64_t head, output u64_t off);
      u64_t a, p, charge, remain, h;
      a = 64'd1 << pad_log2;
      p = (u64_t'(len) + a - 1) & ~(a - 1);
      charge = p;
      h = head;
      if (h >= ring_bytes) h = 0;
      remain = ring_bytes - h;
      if (p > remain) begin
        charge += remain;
        h = 0;
      end
      off = h;
      h += p;
      if (h == ring_bytes) h = 0;
      head = h;
      return charge;
    endfunction

    function void push_res(logic [1:0] kind, u64_t slot, u64_t off, u64_t alloc,
                           u64_t total, u64_t ret, bit last);
      alloc_res_t r;
      r.kind = kind;
      r.slot = slot[9:0];
      r.offset = off[19:0];
      r.alloc_bytes = alloc[21:0];
      r.seg_total = total[6:0];
      r.retired = ret[10:0];
      r.used_bytes = bytes_used[20:0];
      r.is_last = last;
      placements_q.push_back(r);
    endfunction

    function void note_input(seg_item_t it);
      u64_t n, c, lim, outstanding, h, need, off;
      bit [31:0] diff;
      int total, cnt;
      bit ok;
      if (it.op == OP_COMPLETION) begin
        n = 0;
        while (desc_tail != it.done_count && desc_tail != desc_head && n < CLEAN_BUDGET) begin
          c = slot_charge[desc_tail % RING_DEPTH];
          bytes_used = (c > bytes_used) ? 0 : bytes_used - c;
          desc_tail++;
          n++;
        end
        push_res(tbra_pkg::KIND_RETIRE, 0, 0, 0, 0, n, 1'b1);
        return;
      end
      if (pend_cnt < MAX_SEGS) begin
        pend_len[pend_cnt] = it.seg_len;
        pend_cnt++;
      end
      if (seg_seen < 127) seg_seen++;
      if (!it.seg_last) return;
      total = seg_seen;
      cnt = pend_cnt;
      lim = (desc_limit < RING_DEPTH) ? desc_limit : RING_DEPTH;
      diff = desc_head - desc_tail;
      outstanding = u64_t'(diff);
      h = place_head;
      need = 0;
      ok = (total <= MAX_SEGS);
      pend_cnt = 0;
      seg_seen = 0;
      for (int i = 0; i < cnt; i++) need += place_seg(pend_len[i], h, off);
      if (outstanding + cnt > lim || bytes_used + need > ring_bytes) ok = 0;
      if (!ok) begin
        push_res(tbra_pkg::KIND_REJECT, 0, 0, 0, total, 0, 1'b1);
        return;
      end
      bytes_used += need;
      for (int i = 0; i < cnt; i++) begin
        c = place_seg(pend_len[i], place_head, off);
        slot_charge[desc_head % RING_DEPTH] = c & 64'h3FFFFF;
        push_res(tbra_pkg::KIND_PLACED, desc_head % RING_DEPTH, off, c, total, 0,
                 i + 1 == cnt);
        desc_head++;
      end
    endfunction

    task report(string field, u64_t got, u64_t want);
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      errors++;
    endtask

    task check_result(alloc_res_t r);
      alloc_res_t e;
      if (placements_q.size() == 0) begin
        report("unexpected result kind", r.kind, 0);
        return;
      end
      e = placements_q.pop_front();
      if (r.kind !== e.kind) report("kind", r.kind, e.kind);
      if (r.slot !== e.slot) report("slot", r.slot, e.slot);
      if (r.offset !== e.offset) report("offset", r.offset, e.offset);
      if (r.alloc_bytes !== e.alloc_bytes) report("alloc_bytes", r.alloc_bytes, e.alloc_bytes);
      if (r.seg_total !== e.seg_total) report("seg_total", r.seg_total, e.seg_total);
      if (r.retired !== e.retired) report("retired", r.retired, e.retired);
      if (r.used_bytes !== e.used_bytes) report("used_bytes", r.used_bytes, e.used_bytes);
      if (r.is_last !== e.is_last) report("is_last", r.is_last, e.is_last);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [20:0] cfg_wdata;
  bit no_idle;
  bit hold_req;
  int stall_cycles;

  alloc_scoreboard sb = new();

  tbra_if #(.payload_t(seg_item_t)) in_ch (clk);
  tbra_if #(.payload_t(alloc_res_t)) out_ch (clk);

  tx_bounce_ring_allocator_top #(
    .RING_DEPTH(RING_DEPTH),
    .MAX_SEGS(MAX_SEGS),
    .CLEAN_BUDGET(CLEAN_BUDGET)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .in_op(in_ch.data.op),
    .in_seg_len(in_ch.data.seg_len),
    .in_seg_last(in_ch.data.seg_last),
    .in_done_count(in_ch.data.done_count),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_kind(out_ch.data.kind),
    .out_slot(out_ch.data.slot),
    .out_offset(out_ch.data.offset),
    .out_alloc_bytes(out_ch.data.alloc_bytes),
    .out_seg_total(out_ch.data.seg_total),
    .out_retired(out_ch.data.retired),
    .out_used_bytes(out_ch.data.used_bytes),
    .out_is_last(out_ch.data.is_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task send_item(logic op, logic [15:0] len, logic last, logic [31:0] done);
    seg_item_t it;
    it.op = op;
    it.seg_len = len;
    it.seg_last = last;
    it.done_count = done;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
  endtask

  function logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'($urandom);
    return 16'($urandom_range(1, 1500));
  endfunction

  task send_packet(int nseg);
    for (int i = 0; i < nseg; i++) send_item(OP_SEGMENT, pick_len(), i == nseg - 1, 32'd0);
  endtask

  task send_completion();
    logic [31:0] target;
    if ($urandom_range(0, 9) == 0) target = $urandom;
    else target = sb.desc_tail + $urandom_range(0, int'(sb.desc_head - sb.desc_tail) + 2);
    send_item(OP_COMPLETION, 16'($urandom), 1'b0, target);
  endtask

  task run_random(int n_items, int hold_at);
    int sent, nseg, r;
    sent = 0;
    while (sent < n_items) begin
      if (sent >= hold_at && hold_at >= 0 && !hold_req) begin
        hold_req = 1'b1;
        hold_at = -1;
      end
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send_completion();
        sent++;
      end else begin
        if (r < 94) nseg = $urandom_range(1, 6);
        else if (r < 97) nseg = $urandom_range(7, MAX_SEGS);
        else nseg = $urandom_range(MAX_SEGS + 1, MAX_SEGS + 3);
        send_packet(nseg);
        sent += nseg;
      end
    end
  endtask

  // Lets every outstanding result arrive and the block go quiet.
  task drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.placements_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task set_config(logic [20:0] ring, logic [20:0] dlim, logic [20:0] pad);
    cfg_we <= 1'b1;
    cfg_index <= tbra_pkg::CFG_RING_BYTES;
    cfg_wdata <= ring;
    @(posedge clk);
    cfg_index <= tbra_pkg::CFG_DESC_LIMIT;
    cfg_wdata <= dlim;
    @(posedge clk);
    cfg_index <= tbra_pkg::CFG_PAD_LOG2;
    cfg_wdata <= pad;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_cfg(tbra_pkg::CFG_RING_BYTES, ring);
    sb.set_cfg(tbra_pkg::CFG_DESC_LIMIT, dlim);
    sb.set_cfg(tbra_pkg::CFG_PAD_LOG2, pad);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= tbra_pkg::CFG_RING_BYTES;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, padding of zero and full lengths, multi-segment packet,
    // completions that retire nothing and that run past the posted slots.
    send_item(OP_SEGMENT, 16'd0, 1'b1, 32'd0);
    send_item(OP_SEGMENT, 16'hFFFF, 1'b1, 32'd0);
    send_item(OP_COMPLETION, 16'd0, 1'b0, 32'd0);
    send_item(OP_SEGMENT, 16'd100, 1'b0, 32'd0);
    send_item(OP_SEGMENT, 16'd1, 1'b0, 32'd0);
    send_item(OP_SEGMENT, 16'd65, 1'b1, 32'd0);
    send_item(OP_COMPLETION, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    send_packet(MAX_SEGS + 1);
    drain();

    // Small ring without padding: wrap with a wasted tail, tight descriptor limit.
    set_config(21'd1024, 21'd4, 21'd0);
    send_item(OP_SEGMENT, 16'd700, 1'b1, 32'd0);
    send_item(OP_SEGMENT, 16'd700, 1'b1, 32'd0);
    send_item(OP_COMPLETION, 16'd0, 1'b0, sb.desc_head);
    send_item(OP_SEGMENT, 16'd700, 1'b1, 32'd0);
    run_random(20, -1);
    drain();

    // Default-sized ring; the receiver holds off so the block backs up.
    set_config(21'd65536, 21'd1024, 21'd6);
    run_random(30, 10);
    drain();

    set_config(21'd1048576, 21'd1024, 21'd12);
    run_random(25, -1);
    drain();

    // Shrinking the ring leaves the head past its end.
    set_config(21'd1000, 21'd3, 21'd0);
    run_random(20, -1);
    drain();

    set_config(21'd1, 21'd1, 21'd15);
    send_item(OP_SEGMENT, 16'd0, 1'b1, 32'd0);
    send_item(OP_SEGMENT, 16'd1, 1'b1, 32'd0);
    send_item(OP_COMPLETION, 16'd0, 1'b0, 32'hFFFF_FFFF);
    drain();

    set_config(21'd65536, 21'd1024, 21'd6);
    no_idle = 1'b1;
    run_random(40, -1);
    drain();

    if (sb.errors == 0) $display("** tx_bounce_ring_allocator_top: PASSED **");
    else $display("** tx_bounce_ring_allocator_top: FAILED **");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // A transfer on either channel resets the stall counter.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** tx_bounce_ring_allocator_top: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end
endmodule
